>>> design/ihtpp_pkg.sv
// Package for the perturbed-probe identity hash table.
// Holds payload structs, slot status codes and the controller/datapath interface structs.
`default_nettype none
package ihtpp_pkg;
  localparam int LOG2_SLOTS_DEF = 10;
  localparam int KEY_BITS_DEF = 64;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED = 2'd1;
  localparam logic [1:0] ST_TOMB = 2'd2;

  localparam logic [1:0] CFG_SIZE = 2'd0;
  localparam logic [1:0] CFG_SHIFT = 2'd1;

  localparam int CFG_W = 4;

  typedef struct packed {
    logic [1:0] op;
    logic [63:0] key;
    logic key_is_heap;
    logic [63:0] new_value;
  } in_req_t;

  typedef struct packed {
    logic found;
    logic [63:0] old_value;
    logic status;
    logic [10:0] live_items;
    logic [9:0] usable_left;
  } out_res_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request, start probe
    logic rd;       // issue slot read at current index
    logic step;     // advance probe index
    logic note;     // evaluate returned slot
    logic commit;   // write result / update state
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic empty;
    logic limit;
  } dp_stat_t;
endpackage
`default_nettype wire

>>> design/ihtpp_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ihtpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> design/ihtpp_ctrl.sv
// Controller for the hash table: waits out the clear sweep, runs the probe loop, commit and result handoff.
// Depends on ihtpp_pkg.
`default_nettype none
module ihtpp_ctrl
  import ihtpp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire logic     clr_busy,
  input  dp_stat_t      stat,
  output ctl_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic ov_r, ov_nxt;

  // a waiting result does not block the next request; commit waits for it
  wire can_take = !clr_busy;
  assign in_stall = !(state_r == S_IDLE && can_take);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r && out_stall;
    cmd = '0;
    case (state_r)
      S_IDLE: if (in_valid && can_take) begin
        cmd.load = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_EVAL;
      S_EVAL: begin
        cmd.note = 1'b1;
        if (stat.hit || stat.empty || stat.limit) state_nxt = S_DONE;
        else begin
          cmd.step = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DONE: if (!ov_r || !out_stall) begin
        cmd.commit = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

>>> design/ihtpp_dp.sv
// Datapath: hashing, probe index, slot memories, counters, result register.
// Depends on ihtpp_pkg and ihtpp_ram.
`default_nettype none
module ihtpp_dp
  import ihtpp_pkg::*;
#(
  parameter int LOG2_SLOTS = LOG2_SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  in_req_t            in_req,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  ctl_cmd_t           cmd,
  output dp_stat_t           stat,
  output logic               clr_busy,
  output out_res_t           res
);
  localparam int SLOTS = 1 << LOG2_SLOTS;
  localparam int AW = LOG2_SLOTS;
  localparam int LIMIT = SLOTS + KEY_BITS / 5 + 2;
  localparam int NW = $clog2(LIMIT + 1);
  localparam int UW = LOG2_SLOTS; // 2/3 of capacity fits
  localparam int CW = LOG2_SLOTS + 1;

  logic [3:0] lg_r;
  logic [2:0] sh_r;
  logic clr_r;
  logic [AW-1:0] clr_a_r;
  logic [CW-1:0] items_r;
  logic [UW-1:0] usable_r;

  logic [1:0] op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [63:0] nv_r;
  logic [KEY_BITS-1:0] pert_r;
  logic [AW-1:0] cur_r;
  logic [NW-1:0] n_r;
  logic have_free_r;
  logic [AW-1:0] free_r;
  logic hit_r, empty_r;
  logic [AW-1:0] where_r;
  logic [63:0] hval_r;

  logic [AW-1:0] mask;
  logic [AW:0] cap;
  always_comb begin
    cap = (AW+1)'(1) << lg_r;
    mask = AW'(cap - 1'b1);
  end

  function automatic logic [3:0] clamp(input logic [3:0] v);
    if (v < 4'd3) return 4'd3;
    if (32'(v) > LOG2_SLOTS) return 4'(LOG2_SLOTS);
    return v;
  endfunction

  // usable slots of a fresh table, one constant per legal size
  function automatic logic [UW-1:0] two_thirds(input logic [3:0] lg);
    logic [UW-1:0] r;
    r = '0;
    for (int i = 3; i <= LOG2_SLOTS; i++)
      if (lg == 4'(i)) r = UW'(((1 << i) * 2) / 3);
    return r;
  endfunction

  // memories
  logic [1:0] st_q;
  logic [KEY_BITS-1:0] k_q;
  logic [63:0] v_q;
  logic st_we, kv_we;
  logic [AW-1:0] addr;
  logic [1:0] st_wd;
  logic [63:0] v_wd;

  ihtpp_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_st (
    .clk(clk), .we(st_we), .addr(addr), .wdata(st_wd), .rdata(st_q));
  ihtpp_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key (
    .clk(clk), .we(kv_we), .addr(addr), .wdata(key_r), .rdata(k_q));
  ihtpp_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_val (
    .clk(clk), .we(kv_we), .addr(addr), .wdata(v_wd), .rdata(v_q));

  // commit decisions
  logic do_ins, refuse, do_rem, fill_empty, target_empty;
  logic [AW-1:0] tgt;
  always_comb begin
    tgt = have_free_r ? free_r : where_r;
    target_empty = !have_free_r;
    do_ins = 1'b0; refuse = 1'b0; do_rem = 1'b0;
    if (op_r == OP_INSERT) begin
      if (!hit_r) begin
        if (!empty_r && !have_free_r) refuse = 1'b1;
        else if (target_empty && usable_r <= UW'(1)) refuse = 1'b1;
        else do_ins = 1'b1;
      end
    end else if (op_r == OP_REMOVE) do_rem = hit_r;
    fill_empty = do_ins && target_empty;
  end

  always_comb begin
    st_we = 1'b0; kv_we = 1'b0; st_wd = ST_EMPTY; v_wd = nv_r;
    addr = cur_r;
    if (clr_r) begin
      st_we = 1'b1;
      addr = clr_a_r;
    end else if (cmd.commit) begin
      if (hit_r) begin
        addr = where_r;
        if (op_r == OP_INSERT) begin
          kv_we = 1'b1;
        end else if (do_rem) begin
          st_we = 1'b1; st_wd = ST_TOMB; kv_we = 1'b1; v_wd = '0;
        end
      end else if (do_ins) begin
        addr = tgt;
        st_we = 1'b1; st_wd = ST_USED; kv_we = 1'b1;
      end
    end
  end

  // probe bound follows the capacity in use
  logic [NW-1:0] lim_n;
  always_comb lim_n = NW'(cap) + NW'(KEY_BITS / 5 + 2);

  wire slot_hit = st_q == ST_USED && k_q == key_r;
  wire at_lim = n_r + 1'b1 >= lim_n;
  assign stat.hit = slot_hit;
  assign stat.empty = st_q == ST_EMPTY;
  assign stat.limit = at_lim;
  assign clr_busy = clr_r;

  logic [KEY_BITS-1:0] kin, hin, pert_n;
  always_comb begin
    kin = in_req.key[KEY_BITS-1:0];
    hin = in_req.key_is_heap ? (kin >> sh_r) : kin;
    pert_n = pert_r >> 5;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r <= clamp(4'd10);
      sh_r <= 3'd3;
      clr_r <= 1'b1;
      clr_a_r <= '0;
      items_r <= '0;
      usable_r <= two_thirds(clamp(4'd10));
    end else begin
      if (clr_r) begin
        clr_a_r <= clr_a_r + 1'b1;
        if (&clr_a_r) clr_r <= 1'b0;
      end
      if (cfg_we && cfg_index == CFG_SIZE) begin
        lg_r <= clamp(cfg_data);
        clr_r <= 1'b1;
        clr_a_r <= '0;
        items_r <= '0;
        usable_r <= two_thirds(clamp(cfg_data));
      end else if (cfg_we && cfg_index == CFG_SHIFT) begin
        sh_r <= cfg_data[2:0];
      end else if (cmd.commit) begin
        if (do_ins) items_r <= items_r + 1'b1;
        if (do_rem && items_r != '0) items_r <= items_r - 1'b1;
        if (fill_empty) usable_r <= usable_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_req.op;
      key_r <= kin;
      nv_r <= in_req.new_value;
      pert_r <= hin;
      cur_r <= AW'(hin) & mask;
      n_r <= '0;
      have_free_r <= 1'b0;
      hit_r <= 1'b0;
      empty_r <= 1'b0;
    end
    if (cmd.note) begin
      hit_r <= slot_hit;
      empty_r <= st_q == ST_EMPTY;
      where_r <= cur_r;
      hval_r <= v_q;
      if (st_q == ST_TOMB && !have_free_r) begin
        have_free_r <= 1'b1;
        free_r <= cur_r;
      end
    end
    if (cmd.step) begin
      pert_r <= pert_n;
      cur_r <= AW'(({cur_r, 2'b00} + cur_r + 1'b1 + AW'(pert_n))) & mask;
      n_r <= n_r + 1'b1;
    end
    if (cmd.commit) begin
      res.found <= hit_r;
      res.old_value <= hit_r ? hval_r : 64'd0;
      res.status <= refuse;
      res.live_items <= 11'(items_r + CW'(do_ins) - CW'(do_rem && items_r != '0));
      res.usable_left <= 10'(usable_r - UW'(fill_empty));
    end
  end
endmodule
`default_nettype wire

>>> design/identity_hash_table_perturb_probe.sv
// Top level of the perturbed-probe identity hash table.
// Depends on ihtpp_pkg, ihtpp_ctrl, ihtpp_dp (which uses ihtpp_ram).
//
//  channel | direction | ports
//  in      | request   | in_valid, in_stall, in_data
//  out     | result    | out_valid, out_stall, out_data
//  cfg     | write     | cfg_we, cfg_index, cfg_data
//
// A request runs one probe step for each slot probed; each probe step is one
// registered read of the slot memories. After reset and after a table size
// write a clear sweep over all 2^LOG2_SLOTS slots runs with in_stall high.
// The result register holds one result; the next request is taken
// while it waits, and commit waits for it to be drained.
`default_nettype none
module identity_hash_table_perturb_probe
  import ihtpp_pkg::*;
#(
  parameter int LOG2_SLOTS = LOG2_SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_res_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);
  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic clr_busy;

  ihtpp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .clr_busy(clr_busy),
    .stat(stat), .cmd(cmd));

  ihtpp_dp #(.LOG2_SLOTS(LOG2_SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
    .clr_busy(clr_busy), .res(out_data));
endmodule
`default_nettype wire
